// File: hdl/bffa_pkg.sv
// Shared constants, types and helper functions for the bitmap first-free allocator.
// Used by bffa_dp, bffa_ctrl, the top level and the checker; no dependencies.
`default_nettype none

package bffa_pkg;

  localparam int ENTRIES   = 32768;
  localparam int WORD_BITS = 32;
  localparam int RESERVED  = 2;

  localparam int MAP_WORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
  // summary: one full flag per map word, packed GRP_BITS to a summary word
  localparam int GRP_SH    = 5;
  localparam int GRP_BITS  = 1 << GRP_SH;
  localparam int GROUPS    = (MAP_WORDS + GRP_BITS - 1) / GRP_BITS;
  localparam int MAP_DEPTH = GROUPS * GRP_BITS;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int GRP_AW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int WB_IW     = $clog2(WORD_BITS);
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  localparam int IN_IDX_W  = 15;
  localparam int OUT_IDX_W = 15;
  localparam int OUT_CNT_W = 16;
  localparam int CMP_W     = ((IN_IDX_W > IDX_W) ? IN_IDX_W : IDX_W) + 1;

  // entry -> word by reciprocal multiply, exact for any entry below 2**IDX_W
  localparam int DIV_K  = IDX_W + WB_IW;
  localparam int DIV_M  = (2 ** DIV_K + WORD_BITS - 1) / WORD_BITS;
  localparam int DIV_MW = $clog2(DIV_M + 1);
  localparam int DIV_PW = IDX_W + DIV_MW;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic alloc_rd;
    logic alloc_upd;
    logic free_div;
    logic free_rd;
    logic free_upd;
    logic set_full;
    logic set_notused;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_free;
    logic idx_bad;
    logic count_zero;
    logic top_full;
  } dp_sts_t;

  // map word contents right after reset: reserved entries and padding set
  function automatic logic [WORD_BITS-1:0] init_word(input int w);
    logic [WORD_BITS-1:0] r;
    int e;
    r = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      e = w * WORD_BITS + b;
      r[b] = (e < RESERVED) || (e >= ENTRIES);
    end
    return r;
  endfunction

  // summary word after reset: a flag is set when its map word is all ones
  function automatic logic [GRP_BITS-1:0] init_sum(input int g);
    logic [GRP_BITS-1:0] r;
    int w;
    r = '0;
    for (int j = 0; j < GRP_BITS; j++) begin
      w = g * GRP_BITS + j;
      r[j] = (w >= MAP_WORDS) || ((w + 1) * WORD_BITS <= RESERVED);
    end
    return r;
  endfunction

  function automatic logic [GROUPS-1:0] init_top();
    logic [GROUPS-1:0] r;
    for (int g = 0; g < GROUPS; g++) begin
      r[g] = &init_sum(g);
    end
    return r;
  endfunction

  function automatic logic [WB_IW-1:0] first_zero_word(input logic [WORD_BITS-1:0] v);
    logic [WB_IW-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) r = WB_IW'(i);
    end
    return r;
  endfunction

  function automatic logic [GRP_SH-1:0] first_zero_grp(input logic [GRP_BITS-1:0] v);
    logic [GRP_SH-1:0] r;
    r = '0;
    for (int i = GRP_BITS - 1; i >= 0; i--) begin
      if (!v[i]) r = GRP_SH'(i);
    end
    return r;
  endfunction

  function automatic logic [GRP_AW-1:0] first_zero_top(input logic [GROUPS-1:0] v);
    logic [GRP_AW-1:0] r;
    r = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (!v[i]) r = GRP_AW'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/bffa_dp.sv
// Datapath: usage bitmap memory, word-full summary memory, group flags,
// free counter, index arithmetic and the output register. Uses bffa_pkg.
`default_nettype none

module bffa_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  bffa_pkg::dp_cmd_t                cmd,
  output bffa_pkg::dp_sts_t                sts,
  input  wire                              in_kind,
  input  wire  [bffa_pkg::IN_IDX_W-1:0]    in_entry_index,
  output logic [1:0]                       out_status,
  output logic [bffa_pkg::OUT_IDX_W-1:0]   out_granted_index,
  output logic [bffa_pkg::OUT_CNT_W-1:0]   out_free_entries
);

  logic [bffa_pkg::WORD_BITS-1:0] map_mem [bffa_pkg::MAP_DEPTH];
  logic [bffa_pkg::GRP_BITS-1:0]  sum_mem [bffa_pkg::GROUPS];

  logic [bffa_pkg::MAP_AW-1:0]    clr_cnt_r;
  logic [bffa_pkg::WORD_BITS-1:0] map_rd_r;
  logic [bffa_pkg::GRP_BITS-1:0]  sum_rd_r;
  logic [bffa_pkg::GROUPS-1:0]    top_full_r;
  logic [bffa_pkg::CNT_W-1:0]     count_r;
  logic [bffa_pkg::IDX_W-1:0]     idx_r;
  logic [bffa_pkg::MAP_AW-1:0]    word_r;
  logic [bffa_pkg::GRP_AW-1:0]    grp_r;
  logic [bffa_pkg::GRP_SH-1:0]    wsel_r;
  logic [bffa_pkg::WB_IW-1:0]     bit_r;
  bffa_pkg::status_t              status_r;
  logic [bffa_pkg::IDX_W-1:0]     grant_r;
  bffa_pkg::status_t              out_status_r;
  logic [bffa_pkg::IDX_W-1:0]     out_grant_r;
  logic [bffa_pkg::CNT_W-1:0]     out_count_r;

  logic [bffa_pkg::GRP_AW-1:0]    top_pick;
  logic [bffa_pkg::GRP_SH-1:0]    sum_pick;
  logic [bffa_pkg::WB_IW-1:0]     map_pick;
  logic [bffa_pkg::MAP_AW-1:0]    alloc_word;
  logic [bffa_pkg::GRP_AW-1:0]    word_grp;
  logic [bffa_pkg::DIV_PW-1:0]    div_prod;
  logic [bffa_pkg::IDX_W-1:0]     word_base;
  logic [bffa_pkg::IDX_W-1:0]     idx_rem;
  logic [bffa_pkg::WORD_BITS-1:0] alloc_word_val;
  logic [bffa_pkg::WORD_BITS-1:0] free_word_val;
  logic [bffa_pkg::GRP_BITS-1:0]  sel_mask;
  logic                           bit_used;

  logic                           map_re;
  logic [bffa_pkg::MAP_AW-1:0]    map_raddr;
  logic                           map_we;
  logic [bffa_pkg::MAP_AW-1:0]    map_waddr;
  logic [bffa_pkg::WORD_BITS-1:0] map_wdata;
  logic                           sum_re;
  logic [bffa_pkg::GRP_AW-1:0]    sum_raddr;
  logic                           sum_we;
  logic [bffa_pkg::GRP_AW-1:0]    sum_waddr;
  logic [bffa_pkg::GRP_BITS-1:0]  sum_wdata;

  assign top_pick   = bffa_pkg::first_zero_top(top_full_r);
  assign sum_pick   = bffa_pkg::first_zero_grp(sum_rd_r);
  assign map_pick   = bffa_pkg::first_zero_word(map_rd_r);
  assign alloc_word = bffa_pkg::MAP_AW'({grp_r, sum_pick});
  assign word_grp   = bffa_pkg::GRP_AW'(word_r >> bffa_pkg::GRP_SH);

  assign div_prod  = bffa_pkg::DIV_PW'(idx_r) * bffa_pkg::DIV_PW'(bffa_pkg::DIV_M);
  assign word_base = bffa_pkg::IDX_W'(int'(word_r) * bffa_pkg::WORD_BITS);
  assign idx_rem   = idx_r - word_base;

  assign sel_mask       = bffa_pkg::GRP_BITS'(1) << wsel_r;
  assign alloc_word_val = map_rd_r | (bffa_pkg::WORD_BITS'(1) << map_pick);
  assign free_word_val  = map_rd_r & ~(bffa_pkg::WORD_BITS'(1) << bit_r);
  assign bit_used       = map_rd_r[bit_r];

  assign sts.clr_last   = (clr_cnt_r == bffa_pkg::MAP_AW'(bffa_pkg::MAP_DEPTH - 1));
  assign sts.req_free   = (in_kind == bffa_pkg::KIND_FREE);
  assign sts.idx_bad    = (bffa_pkg::CMP_W'(in_entry_index) >=
                           bffa_pkg::CMP_W'(bffa_pkg::ENTRIES));
  assign sts.count_zero = (count_r == '0);
  assign sts.top_full   = &top_full_r;

  // read ports
  always_comb begin
    map_re    = cmd.alloc_rd | cmd.free_rd;
    map_raddr = cmd.alloc_rd ? alloc_word : word_r;
    sum_re    = (cmd.accept & ~sts.req_free) | cmd.free_rd;
    sum_raddr = cmd.accept ? top_pick : word_grp;
  end

  // write ports: clearing sweep, allocate update, free update
  always_comb begin
    map_we    = 1'b0;
    map_waddr = word_r;
    map_wdata = alloc_word_val;
    sum_we    = 1'b0;
    sum_waddr = grp_r;
    sum_wdata = sum_rd_r;
    if (cmd.clr_step) begin
      map_we    = 1'b1;
      map_waddr = clr_cnt_r;
      map_wdata = bffa_pkg::init_word(int'(clr_cnt_r));
      sum_we    = (int'(clr_cnt_r) < bffa_pkg::GROUPS);
      sum_waddr = bffa_pkg::GRP_AW'(clr_cnt_r);
      sum_wdata = bffa_pkg::init_sum(int'(clr_cnt_r));
    end else if (cmd.alloc_upd) begin
      map_we    = 1'b1;
      sum_we    = 1'b1;
      sum_wdata = (&alloc_word_val) ? (sum_rd_r | sel_mask) : sum_rd_r;
    end else if (cmd.free_upd && bit_used) begin
      map_we    = 1'b1;
      map_wdata = free_word_val;
      sum_we    = 1'b1;
      sum_wdata = sum_rd_r & ~sel_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re) map_rd_r <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (sum_re) sum_rd_r <= sum_mem[sum_raddr];
  end

  // control-side state: sweep counter, group flags, free count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      top_full_r <= bffa_pkg::init_top();
      count_r    <= bffa_pkg::CNT_W'(bffa_pkg::ENTRIES - bffa_pkg::RESERVED);
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.alloc_upd) begin
        top_full_r[grp_r] <= &sum_wdata;
        count_r           <= count_r - 1'b1;
      end else if (cmd.free_upd && bit_used) begin
        top_full_r[grp_r] <= 1'b0;
        count_r           <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= bffa_pkg::IDX_W'(in_entry_index);
      grp_r <= top_pick;
    end
    if (cmd.alloc_rd) begin
      word_r <= alloc_word;
      wsel_r <= sum_pick;
    end
    if (cmd.free_div) word_r <= bffa_pkg::MAP_AW'(div_prod >> bffa_pkg::DIV_K);
    if (cmd.free_rd) begin
      grp_r  <= word_grp;
      wsel_r <= word_r[bffa_pkg::GRP_SH-1:0];
      bit_r  <= idx_rem[bffa_pkg::WB_IW-1:0];
    end
    if (cmd.alloc_upd) begin
      status_r <= bffa_pkg::ST_OK;
      grant_r  <= bffa_pkg::IDX_W'(int'(word_r) * bffa_pkg::WORD_BITS + int'(map_pick));
    end else if (cmd.free_upd) begin
      status_r <= bit_used ? bffa_pkg::ST_OK : bffa_pkg::ST_NOT_USED;
      grant_r  <= '0;
    end else if (cmd.set_full) begin
      status_r <= bffa_pkg::ST_FULL;
      grant_r  <= '0;
    end else if (cmd.set_notused) begin
      status_r <= bffa_pkg::ST_NOT_USED;
      grant_r  <= '0;
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_grant_r  <= grant_r;
      out_count_r  <= count_r;
    end
  end

  assign out_status        = out_status_r;
  assign out_granted_index = bffa_pkg::OUT_IDX_W'(out_grant_r);
  assign out_free_entries  = bffa_pkg::OUT_CNT_W'(out_count_r);

endmodule

`default_nettype wire

// File: hdl/bffa_ctrl.sv
// Controller: sequences the clearing sweep and the allocate / free steps,
// and owns the input stall and output valid. Uses bffa_pkg.
`default_nettype none

module bffa_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire                out_stall,
  input  bffa_pkg::dp_sts_t  sts,
  output bffa_pkg::dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ARD   = 8'b0000_0100,
    S_AUPD  = 8'b0000_1000,
    S_FDIV  = 8'b0001_0000,
    S_FRD   = 8'b0010_0000,
    S_FUPD  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;
  logic   slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign take      = in_valid && (state_r == S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          cmd.accept = 1'b1;
          if (sts.req_free) begin
            if (sts.idx_bad) begin
              cmd.set_notused = 1'b1;
              state_nxt       = S_DONE;
            end else begin
              state_nxt = S_FDIV;
            end
          end else if (sts.count_zero || sts.top_full) begin
            cmd.set_full = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_ARD;
          end
        end
      end
      S_ARD: begin
        cmd.alloc_rd = 1'b1;
        state_nxt    = S_AUPD;
      end
      S_AUPD: begin
        cmd.alloc_upd = 1'b1;
        state_nxt     = S_DONE;
      end
      S_FDIV: begin
        cmd.free_div = 1'b1;
        state_nxt    = S_FRD;
      end
      S_FRD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FUPD;
      end
      S_FUPD: begin
        cmd.free_upd = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        // hold the finished word until the output register is open
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bitmap_first_free_allocator.sv
// Sequence: allocate runs S_ARD then S_AUPD, free runs S_FDIV, S_FRD then S_FUPD, and
// both end in S_DONE; an out of range free and an allocate when full go straight to S_DONE.
// One item in flight at a time; the input stays stalled until S_DONE has loaded the
// finished word, which waits there for the output register to open.
// Reset: a clearing sweep over all MAP_DEPTH map words (1024 at default) rewrites both
// memories with reserved entries marked used; in_stall stays high until done.
`default_nettype none

module bitmap_first_free_allocator (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_kind,
  input  wire  [bffa_pkg::IN_IDX_W-1:0]    in_entry_index,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [1:0]                       out_status,
  output logic [bffa_pkg::OUT_IDX_W-1:0]   out_granted_index,
  output logic [bffa_pkg::OUT_CNT_W-1:0]   out_free_entries
);

  bffa_pkg::dp_cmd_t cmd;
  bffa_pkg::dp_sts_t sts;

  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bffa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_kind),
    .in_entry_index    (in_entry_index),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_free_entries  (out_free_entries)
  );

endmodule

`default_nettype wire

// File: hdl/bffa_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Uses bffa_pkg for status codes.
`default_nettype none

module bffa_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_stall,
  input wire                            out_valid,
  input wire                            out_stall,
  input wire [1:0]                      out_status,
  input wire [bffa_pkg::OUT_IDX_W-1:0]  out_granted_index,
  input wire [bffa_pkg::OUT_CNT_W-1:0]  out_free_entries
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_granted_index) && $stable(out_free_entries))
    else $error("stalled result word changed");

  // one item at a time: an accepted word closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after acceptance");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != bffa_pkg::ST_OK) |-> out_granted_index == '0)
    else $error("failed item carries a granted index");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bffa_pkg::ST_FULL) |-> out_free_entries == '0)
    else $error("no-space reported with free entries left");

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_granted_index (out_granted_index),
  .out_free_entries  (out_free_entries)
);

`default_nettype wire

// File: dv/bitmap_first_free_allocator_tb.sv
// Self-checking testbench for bitmap_first_free_allocator: directed and random
// allocate/free traffic, each reply checked against a shadow copy of the used/free bitmap.
// Depends on bffa_pkg (hdl/bffa_pkg.sv) and the allocator top level.
`default_nettype none

module bitmap_first_free_allocator_tb;

  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct {
    bffa_pkg::status_t               status;
    logic [bffa_pkg::OUT_IDX_W-1:0]  granted;
    logic [bffa_pkg::OUT_CNT_W-1:0]  free_cnt;
  } outcome_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_kind = 1'b0;
  logic [bffa_pkg::IN_IDX_W-1:0]   in_entry_index = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      out_status;
  logic [bffa_pkg::OUT_IDX_W-1:0]  out_granted_index;
  logic [bffa_pkg::OUT_CNT_W-1:0]  out_free_entries;

  // shadow of the allocator state
  logic [bffa_pkg::WORD_BITS-1:0]  map_shadow [bffa_pkg::MAP_WORDS];
  int                              free_shadow;
  int                              scan_floor;  // every word below this one is all ones

  outcome_t              outcome_q[$];
  int                    held_q[$];
  bit                    quiet_mode = 1'b0;
  int                    cycle_count = 0;
  int                    mismatches = 0;
  int                    replies_checked = 0;
  int                    n_granted = 0;
  int                    n_full = 0;
  int                    n_not_used = 0;

  bitmap_first_free_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_entry_index    (in_entry_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_free_entries  (out_free_entries)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies pending", cycle_count, outcome_q.size());
      $display("bitmap_first_free_allocator_tb NOT OK");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void reset_shadow();
    int e;
    for (int w = 0; w < bffa_pkg::MAP_WORDS; w++) map_shadow[w] = '0;
    for (e = 0; e < bffa_pkg::RESERVED && e < bffa_pkg::ENTRIES; e++)
      map_shadow[e / bffa_pkg::WORD_BITS][e % bffa_pkg::WORD_BITS] = 1'b1;
    // padding bits of a partial last word stay set
    for (e = bffa_pkg::ENTRIES; e < bffa_pkg::MAP_WORDS * bffa_pkg::WORD_BITS; e++)
      map_shadow[e / bffa_pkg::WORD_BITS][e % bffa_pkg::WORD_BITS] = 1'b1;
    free_shadow = bffa_pkg::ENTRIES - bffa_pkg::RESERVED;
    scan_floor = 0;
  endfunction

  function automatic outcome_t predict_outcome(input bffa_pkg::kind_t kind,
                                               input logic [bffa_pkg::IN_IDX_W-1:0] idx);
    outcome_t r;
    int w;
    int b;
    int e;
    bit found;
    logic [bffa_pkg::WORD_BITS-1:0] ones;
    r.status = bffa_pkg::ST_OK;
    r.granted = '0;
    found = 1'b0;
    ones = '1;
    if (kind == bffa_pkg::KIND_ALLOC) begin
      if (free_shadow == 0) begin
        r.status = bffa_pkg::ST_FULL;
      end else begin
        w = scan_floor;
        while (!found && w < bffa_pkg::MAP_WORDS) begin
          if (map_shadow[w] != ones) begin
            b = 0;
            while (map_shadow[w][b]) b++;
            map_shadow[w][b] = 1'b1;
            r.granted = bffa_pkg::OUT_IDX_W'(w * bffa_pkg::WORD_BITS + b);
            found = 1'b1;
          end else begin
            w++;
          end
        end
        scan_floor = w;
        if (found) free_shadow--;
        else r.status = bffa_pkg::ST_FULL;
      end
    end else begin
      e = int'(idx);
      if (e >= bffa_pkg::ENTRIES ||
          !map_shadow[e / bffa_pkg::WORD_BITS][e % bffa_pkg::WORD_BITS]) begin
        r.status = bffa_pkg::ST_NOT_USED;
      end else begin
        map_shadow[e / bffa_pkg::WORD_BITS][e % bffa_pkg::WORD_BITS] = 1'b0;
        free_shadow++;
        if (e / bffa_pkg::WORD_BITS < scan_floor) scan_floor = e / bffa_pkg::WORD_BITS;
      end
    end
    r.free_cnt = bffa_pkg::OUT_CNT_W'(free_shadow);
    return r;
  endfunction

  // one request word; valid stays high across back-to-back words
  task automatic send_word(input bffa_pkg::kind_t kind,
                           input logic [bffa_pkg::IN_IDX_W-1:0] idx,
                           output outcome_t res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_entry_index <= idx;
    do @(posedge clk); while (in_stall !== 1'b0);
    res = predict_outcome(kind, idx);
    outcome_q.push_back(res);
    case (res.status)
      bffa_pkg::ST_OK:       if (kind == bffa_pkg::KIND_ALLOC) n_granted++;
      bffa_pkg::ST_FULL:     n_full++;
      bffa_pkg::ST_NOT_USED: n_not_used++;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
  endtask

  // receiver back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    outcome_t x;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: reply word with nothing expected: status %0d index %0d free %0d",
                 $time, out_status, out_granted_index, out_free_entries);
        mismatches++;
      end else begin
        x = outcome_q.pop_front();
        replies_checked++;
        if (out_status !== x.status) begin
          $display("%0t: status expected %0d actual %0d", $time, x.status, out_status);
          mismatches++;
        end
        if (out_granted_index !== x.granted) begin
          $display("%0t: granted_index expected %0d actual %0d",
                   $time, x.granted, out_granted_index);
          mismatches++;
        end
        if (out_free_entries !== x.free_cnt) begin
          $display("%0t: free_entries expected %0d actual %0d",
                   $time, x.free_cnt, out_free_entries);
          mismatches++;
        end
      end
    end
  end

  task automatic test_directed();
    outcome_t r;
    send_word(bffa_pkg::KIND_ALLOC, '0, r);      // first grant skips the reserved entries
    send_word(bffa_pkg::KIND_ALLOC, '1, r);      // index ignored on allocate
    send_word(bffa_pkg::KIND_FREE, 15'd0, r);    // reserved entries may be freed
    send_word(bffa_pkg::KIND_FREE, 15'd1, r);
    send_word(bffa_pkg::KIND_ALLOC, 15'h5555, r);
    send_word(bffa_pkg::KIND_ALLOC, '0, r);
    send_word(bffa_pkg::KIND_FREE, '1, r);       // top entry never handed out
    send_word(bffa_pkg::KIND_FREE, 15'h5555, r);
    send_word(bffa_pkg::KIND_FREE, 15'h2AAA, r);
    send_word(bffa_pkg::KIND_FREE, 15'd2, r);
    send_word(bffa_pkg::KIND_FREE, 15'd2, r);    // double free
    send_word(bffa_pkg::KIND_ALLOC, '0, r);
    send_word(bffa_pkg::KIND_ALLOC, '0, r);
    send_word(bffa_pkg::KIND_FREE, 15'd3, r);
    send_word(bffa_pkg::KIND_FREE, 15'd4, r);
    send_word(bffa_pkg::KIND_ALLOC, '0, r);
    wait_drained();
  endtask

  task automatic test_random_mix(input int n_items);
    outcome_t r;
    int pick;
    int k;
    held_q.delete();
    for (int e = 0; e < bffa_pkg::ENTRIES; e++)
      if (map_shadow[e / bffa_pkg::WORD_BITS][e % bffa_pkg::WORD_BITS]) held_q.push_back(e);
    for (int i = 0; i < n_items; i++) begin
      if (i % 150 == 0 && i != 0) wait_drained();  // sender holds off until all replies are in
      quiet_mode = (i / 150 == 2);
      pick = $urandom_range(0, 99);
      if (pick < 50 || (pick < 85 && held_q.size() == 0)) begin
        send_word(bffa_pkg::KIND_ALLOC, bffa_pkg::IN_IDX_W'($urandom), r);
        if (r.status == bffa_pkg::ST_OK) held_q.push_back(int'(r.granted));
      end else if (pick < 85) begin
        k = $urandom_range(0, held_q.size() - 1);
        send_word(bffa_pkg::KIND_FREE, bffa_pkg::IN_IDX_W'(held_q[k]), r);
        held_q.delete(k);
      end else begin
        send_word(bffa_pkg::KIND_FREE, bffa_pkg::IN_IDX_W'($urandom), r);
      end
      // a lucky random free of a held entry: drop it from the list
      if (pick >= 85 && r.status == bffa_pkg::ST_OK) begin
        for (int j = held_q.size() - 1; j >= 0; j--)
          if (held_q[j] == int'(in_entry_index)) held_q.delete(j);
      end
    end
    quiet_mode = 1'b0;
    wait_drained();
  endtask

  initial begin
    reset_shadow();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix(750);
    repeat (8) @(posedge clk);
    $display("%0d replies checked: %0d grants, %0d no-space, %0d frees of unused entries",
             replies_checked, n_granted, n_full, n_not_used);
    $display("directed allocate/free cases plus a random mix with stalls and drains");
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("bitmap_first_free_allocator_tb OK");
    end else begin
      $display("bitmap_first_free_allocator_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
